>>> hw/rtl/dbs_pkg.sv
package dbs_pkg;

    localparam int MAX_ORDER_DEF = 16;
    localparam int MAX_ALPHABET  = 8;

    localparam int DIGIT_W   = 3;
    localparam int CHAR_W    = 8;
    localparam int K_W       = 4;
    localparam int N_W       = 5;
    localparam int LEN_W     = 49;
    localparam int CHARS_W   = 64;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS      = 3'd3;

    localparam logic [K_W-1:0]     K_RESET     = 4'd2;
    localparam logic [N_W-1:0]     N_RESET     = 5'd3;
    localparam logic [LEN_W-1:0]   LEN_RESET   = 49'h1_0000_0000_0000;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;
    localparam logic [CHARS_W-1:0] CHARS_RESET = {48'd0, CHAR_ZERO + 8'd1, CHAR_ZERO};

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_SINIT,
        S_SRD,
        S_SCHK,
        S_CRD,
        S_CWR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic rd_emit;
        logic latch_sym;
        logic init_i;
        logic rd_i;
        logic dec_i;
        logic inc_wr;
        logic rd_copy;
        logic wr_copy;
        logic pos_one;
        logic set_fin;
        logic finalize;
    } t_dp_cmd;

    typedef struct packed {
        logic finished;
        logic len_reached;
        logic pos_past;
        logic i_zero;
        logic digit_top;
        logic copy_done;
        logic divisible;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hw/rtl/dbs_if.sv
interface dbs_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface dbs_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] symbol_index;
    logic [7:0] symbol_char;
    logic       last;

    modport source (output valid, output symbol_index, output symbol_char, output last,
                    input ready);
    modport sink   (input valid, input symbol_index, input symbol_char, input last,
                    output ready);
endinterface

interface dbs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [63:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

>>> hw/rtl/dbs_ram.sv
module dbs_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/dbs_ctrl.sv
module dbs_ctrl import dbs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dbs_in_if.sink    i_req,
    input  t_dp_stat  i_stat,
    output t_dp_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   req_xfer;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_xfer    = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_xfer && !i_req.restart && !i_stat.finished && !i_stat.len_reached) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT:  n_state = i_stat.pos_past ? S_SINIT : S_DONE;
            S_SINIT: n_state = S_SRD;
            S_SRD:   n_state = i_stat.i_zero ? S_DONE : S_SCHK;
            S_SCHK:  n_state = i_stat.digit_top ? S_SRD : S_CRD;
            S_CRD: begin
                if (!i_stat.copy_done) begin
                    n_state = S_CWR;
                end else if (i_stat.divisible) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SINIT;
                end
            end
            S_CWR:   n_state = S_CRD;
            S_DONE:  n_state = i_stat.out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    if (i_req.restart) begin
                        o_cmd.start = 1'b1;
                    end else if (!i_stat.finished) begin
                        if (i_stat.len_reached) begin
                            o_cmd.set_fin = 1'b1;
                        end else begin
                            o_cmd.rd_emit = 1'b1;
                        end
                    end
                end
            end
            S_EMIT:  o_cmd.latch_sym = 1'b1;
            S_SINIT: o_cmd.init_i = 1'b1;
            S_SRD: begin
                // no digit left to bump: the last prenecklace was reached
                if (i_stat.i_zero) begin
                    o_cmd.set_fin = 1'b1;
                end else begin
                    o_cmd.rd_i = 1'b1;
                end
            end
            S_SCHK: begin
                if (i_stat.digit_top) begin
                    o_cmd.dec_i = 1'b1;
                end else begin
                    o_cmd.inc_wr = 1'b1;
                end
            end
            S_CRD: begin
                if (!i_stat.copy_done) begin
                    o_cmd.rd_copy = 1'b1;
                end else if (i_stat.divisible) begin
                    o_cmd.pos_one = 1'b1;
                end
            end
            S_CWR:   o_cmd.wr_copy = 1'b1;
            S_DONE:  o_cmd.finalize = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> hw/rtl/dbs_datapath.sv
module dbs_datapath import dbs_pkg::*; #(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    dbs_cfg_if.sink   i_cfg,
    dbs_out_if.source o_sym
);

    localparam int DEPTH = MAX_ORDER + 1;
    localparam int AW    = $clog2(MAX_ORDER + 1);
    localparam int CW    = $clog2(MAX_ORDER + 2);

    logic [K_W-1:0]     r_k_raw;
    logic [N_W-1:0]     r_n_raw;
    logic [LEN_W-1:0]   r_max_len;
    logic [CHARS_W-1:0] r_chars;

    logic [AW-1:0]      r_p;
    logic [CW-1:0]      r_pos;
    logic [LEN_W-1:0]   r_count;
    logic               r_finished;
    logic [AW-1:0]      r_i;
    logic [CW-1:0]      r_j;
    logic [DIGIT_W-1:0] r_sym;
    logic [DEPTH-1:0]   r_dig_valid;
    logic               r_rd_valid;

    logic               r_out_valid;
    logic [DIGIT_W-1:0] r_out_idx;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;

    logic               cfg_xfer;
    logic               cfg_start;
    logic               seq_start;
    logic [K_W-1:0]     eff_k;
    logic [AW-1:0]      eff_n;
    logic [DIGIT_W-1:0] k_top;
    logic [CW-1:0]      pos_clamp;
    logic [LEN_W-1:0]   count_inc;
    logic               len_hit;
    logic [MAX_ORDER:0] div_mask;
    logic               out_free;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [DIGIT_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [DIGIT_W-1:0] ram_q;
    logic [DIGIT_W-1:0] rd_m;

    assign i_cfg.ready = 1'b1;
    assign cfg_xfer    = i_cfg.valid;
    assign cfg_start   = cfg_xfer && (i_cfg.reg_index == CFG_ALPHABET ||
                                      i_cfg.reg_index == CFG_ORDER);
    assign seq_start   = i_cmd.start || cfg_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_raw   <= K_RESET;
            r_n_raw   <= N_RESET;
            r_max_len <= LEN_RESET;
            r_chars   <= CHARS_RESET;
        end else if (cfg_xfer) begin
            unique case (i_cfg.reg_index)
                CFG_ALPHABET:   r_k_raw   <= i_cfg.wr_data[K_W-1:0];
                CFG_ORDER:      r_n_raw   <= i_cfg.wr_data[N_W-1:0];
                CFG_MAX_LENGTH: r_max_len <= i_cfg.wr_data[LEN_W-1:0];
                CFG_CHARS:      r_chars   <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    // saturate k and n into their legal ranges
    always_comb begin
        if (r_k_raw < K_W'(2)) begin
            eff_k = K_W'(2);
        end else if (r_k_raw > K_W'(MAX_ALPHABET)) begin
            eff_k = K_W'(MAX_ALPHABET);
        end else begin
            eff_k = r_k_raw;
        end
        if (r_n_raw == '0) begin
            eff_n = AW'(1);
        end else if (32'(r_n_raw) > 32'(MAX_ORDER)) begin
            eff_n = AW'(MAX_ORDER);
        end else begin
            eff_n = AW'(r_n_raw);
        end
    end

    assign k_top = DIGIT_W'(eff_k - K_W'(1));

    // divisors of n, one bit per candidate period
    always_comb begin
        div_mask = '0;
        for (int d = 1; d <= MAX_ORDER; d++) begin
            for (int m = 1; m <= MAX_ORDER; m++) begin
                if (d * m <= MAX_ORDER && int'(eff_n) == d * m) begin
                    div_mask[d] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_pos == '0 || r_pos > CW'(MAX_ORDER)) begin
            pos_clamp = CW'(1);
        end else begin
            pos_clamp = r_pos;
        end
    end

    // never-written digits read as zero
    assign rd_m = r_rd_valid ? ram_q : '0;

    always_comb begin
        ram_re = i_cmd.rd_emit || i_cmd.rd_i || i_cmd.rd_copy;
        if (i_cmd.rd_emit) begin
            ram_raddr = pos_clamp[AW-1:0];
        end else if (i_cmd.rd_i) begin
            ram_raddr = r_i;
        end else begin
            ram_raddr = AW'(r_j - CW'(r_i));
        end
        ram_we    = i_cmd.inc_wr || i_cmd.wr_copy;
        ram_waddr = i_cmd.inc_wr ? r_i : r_j[AW-1:0];
        ram_wdata = i_cmd.inc_wr ? DIGIT_W'(rd_m + DIGIT_W'(1)) : rd_m;
    end

    dbs_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DEPTH)
    ) u_digits (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_q)
    );

    assign count_inc = r_count + LEN_W'(1);
    assign len_hit   = (count_inc >= r_max_len);
    assign out_free  = !r_out_valid || o_sym.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p         <= AW'(1);
            r_pos       <= CW'(1);
            r_count     <= '0;
            r_finished  <= 1'b0;
            r_dig_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (seq_start) begin
                r_p         <= AW'(1);
                r_pos       <= CW'(1);
                r_count     <= '0;
                r_finished  <= 1'b0;
                r_dig_valid <= '0;
            end else begin
                if (i_cmd.rd_emit) begin
                    r_pos <= pos_clamp + CW'(1);
                end
                if (i_cmd.pos_one) begin
                    r_pos <= CW'(1);
                end
                if (i_cmd.inc_wr) begin
                    r_p <= r_i;
                end
                if (ram_we) begin
                    r_dig_valid[ram_waddr] <= 1'b1;
                end
                if (i_cmd.set_fin) begin
                    r_finished <= 1'b1;
                end
                if (i_cmd.finalize) begin
                    r_count <= count_inc;
                    if (len_hit) begin
                        r_finished <= 1'b1;
                    end
                end
            end
            if (i_cmd.finalize) begin
                r_out_valid <= 1'b1;
            end else if (o_sym.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_rd_valid <= r_dig_valid[ram_raddr];
        end
        if (i_cmd.init_i) begin
            r_i <= eff_n;
        end else if (i_cmd.dec_i) begin
            r_i <= r_i - AW'(1);
        end
        if (i_cmd.inc_wr) begin
            r_j <= CW'(r_i) + CW'(1);
        end else if (i_cmd.wr_copy) begin
            r_j <= r_j + CW'(1);
        end
        if (i_cmd.latch_sym) begin
            r_sym <= rd_m;
        end
        if (i_cmd.finalize) begin
            r_out_idx  <= r_sym;
            r_out_char <= r_chars[{r_sym, 3'b000} +: CHAR_W];
            r_out_last <= r_finished || len_hit;
        end
    end

    assign o_sym.valid        = r_out_valid;
    assign o_sym.symbol_index = r_out_idx;
    assign o_sym.symbol_char  = r_out_char;
    assign o_sym.last         = r_out_last;

    always_comb begin
        o_stat.finished    = r_finished;
        o_stat.len_reached = (r_count >= r_max_len);
        o_stat.pos_past    = (r_pos > CW'(r_p));
        o_stat.i_zero      = (r_i == '0);
        o_stat.digit_top   = (rd_m >= k_top);
        o_stat.copy_done   = (r_j > CW'(eff_n));
        o_stat.divisible   = div_mask[r_p];
        o_stat.out_free    = out_free;
    end

endmodule

>>> hw/rtl/de_bruijn_sequence_generator.sv
// channel  dir  handshake      payload
// i_req    in   valid/ready    restart
// i_cfg    in   valid/ready    reg_index[2:0], wr_data[63:0]
// o_sym    out  valid/ready    symbol_index[2:0], symbol_char[7:0], last
//
// Restart, a request after the end, or an empty request: no result; the block stays idle.
// A symbol that stays in the current prenecklace goes from S_EMIT straight to S_DONE.
// Otherwise each successor step scans digits (S_SRD, S_SCHK) and then copies
// digits (S_CRD, S_CWR), all through the single read port of the digit RAM.
// Synchronous reset; digits clear through per-entry valid bits, no clearing pass.
// A stalled result holds in o_sym; the next request is taken meanwhile.
module de_bruijn_sequence_generator import dbs_pkg::*; #(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dbs_in_if.sink    i_req,
    dbs_cfg_if.sink   i_cfg,
    dbs_out_if.source o_sym
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    dbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    dbs_datapath #(
        .MAX_ORDER (MAX_ORDER)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .i_cfg   (i_cfg),
        .o_sym   (o_sym)
    );

endmodule

>>> hw/rtl/dbs_checker.sv
module dbs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_restart,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_index,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);

    // a pending result is held until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_out_index) && $stable(i_out_char) && $stable(i_out_last)))
        else $error("result payload changed while stalled");

    // a new result only comes out of a busy period
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without work in progress");

    a_restart_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_restart) |=> !$rose(i_out_valid))
        else $error("restart produced a result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

endmodule

bind de_bruijn_sequence_generator dbs_checker u_dbs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_in_restart (i_req.restart),
    .i_out_valid  (o_sym.valid),
    .i_out_ready  (o_sym.ready),
    .i_out_index  (o_sym.symbol_index),
    .i_out_char   (o_sym.symbol_char),
    .i_out_last   (o_sym.last)
);
